// ----- rtl/core/dfr_pkg.sv -----
// shared constants and state type for the deframer core
package dfr_pkg;

	localparam int unsigned STORE_DEPTH_DEF = 512;
	localparam int unsigned FRAME_OVERHEAD  = 4;
	localparam int unsigned MAX_RESULTS     = 64;
	localparam logic [7:0]  HEADER_RESET    = 8'd170;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HUNT,
		S_HUNT_CHK,
		S_CMD,
		S_LEN,
		S_SUM,
		S_CHK,
		S_CNT,
		S_FIN
	} state_t;

endpackage

// ----- rtl/core/sync_length_checksum_deframer_core.sv -----
// frame deframer: circular byte store, sequencer that hunts, sums and checks frames
// each input byte is stored, then the store is hunted position by position for the header;
// at a header command and length are read, payload summed, checksum checked and a good frame
// counted; the scan ends when the store runs empty; a checksum failure rescans from the next byte
// the next transfer is taken once the scan ends and the last descriptor is loaded
// arst_n clears counters, fill count and per-command valid bits; header resets to 170;
// store contents are not cleared
module sync_length_checksum_deframer_core #(
	parameter int unsigned STORE_DEPTH = dfr_pkg::STORE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  command,
	output logic [7:0]  payload_length,
	output logic [7:0]  frame_checksum,
	output logic [31:0] valid_frames,
	output logic [31:0] command_frames,
	output logic [31:0] error_count,
	output logic [31:0] drop_count,
	output logic [31:0] received_bytes,
	output logic        last
);

	localparam int unsigned AW = $clog2(STORE_DEPTH);
	localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
	localparam logic [AW:0] DEPTH_W = (AW+1)'(STORE_DEPTH);
	localparam int unsigned RCW = $clog2(dfr_pkg::MAX_RESULTS + 1);

	function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
		logic [AW:0] t;
		begin
			t = (s >= DEPTH_W) ? s - DEPTH_W : s;
			wrap = t[AW-1:0];
		end
	endfunction

	dfr_pkg::state_t state_q, state_nx;

	logic [7:0]    header_q;
	logic [7:0]    mem [STORE_DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] raddr;
	logic [AW-1:0] head_q;
	logic [CW-1:0] fill_q;
	logic [7:0]    cmd_q, len_q, sum_q, idx_q;
	logic [RCW-1:0] count_q;

	logic [31:0] pc_mem [256];
	logic [31:0] pc_rdata_q;
	logic [255:0] pc_vld_q;
	logic [31:0] pc_new;

	logic [31:0] recv_q, disc_q, err_q, valid_q;

	logic        pend_q;
	logic [7:0]  p_cmd_q, p_len_q, p_chk_q;
	logic [31:0] p_valid_q, p_cmdcnt_q, p_err_q, p_disc_q, p_recv_q;

	logic        accept, out_free, full, hdr_hit, short_frame, sum_done, move_ok;
	logic        load_out;
	logic [8:0]  size;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign full     = (fill_q == DEPTH_C);
	assign hdr_hit  = (rdata_q == header_q);
	assign size     = {1'b0, len_q} + 9'(dfr_pkg::FRAME_OVERHEAD);
	assign short_frame = (fill_q < CW'({1'b0, rdata_q} + 9'(dfr_pkg::FRAME_OVERHEAD)));
	assign sum_done = (idx_q == len_q - 8'd1);
	assign move_ok  = !pend_q || out_free;
	assign pc_new   = pc_vld_q[cmd_q] ? pc_rdata_q + 32'd1 : 32'd1;
	assign load_out = (state_q == dfr_pkg::S_CNT && move_ok && pend_q) ||
		(state_q == dfr_pkg::S_FIN && pend_q && out_free);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			dfr_pkg::S_IDLE:     if (accept) state_nx = dfr_pkg::S_HUNT;
			dfr_pkg::S_HUNT:     state_nx = (fill_q == '0) ? dfr_pkg::S_FIN : dfr_pkg::S_HUNT_CHK;
			dfr_pkg::S_HUNT_CHK: begin
				if (!hdr_hit) state_nx = dfr_pkg::S_HUNT;
				else if (fill_q < CW'(dfr_pkg::FRAME_OVERHEAD)) state_nx = dfr_pkg::S_FIN;
				else state_nx = dfr_pkg::S_CMD;
			end
			dfr_pkg::S_CMD:      state_nx = dfr_pkg::S_LEN;
			dfr_pkg::S_LEN: begin
				if (short_frame) state_nx = dfr_pkg::S_FIN;
				else if (rdata_q == 8'd0) state_nx = dfr_pkg::S_CHK;
				else state_nx = dfr_pkg::S_SUM;
			end
			dfr_pkg::S_SUM:      if (sum_done) state_nx = dfr_pkg::S_CHK;
			dfr_pkg::S_CHK: begin
				if (rdata_q != ~sum_q) state_nx = dfr_pkg::S_HUNT;
				else if (count_q >= RCW'(dfr_pkg::MAX_RESULTS)) state_nx = dfr_pkg::S_FIN;
				else state_nx = dfr_pkg::S_CNT;
			end
			dfr_pkg::S_CNT:      if (move_ok) state_nx = dfr_pkg::S_HUNT;
			dfr_pkg::S_FIN:      if (!pend_q || out_free) state_nx = dfr_pkg::S_IDLE;
			default:             state_nx = dfr_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake and store read address
	always_comb begin
		in_stall = 1'b1;
		raddr    = head_q;
		unique case (state_q)
			dfr_pkg::S_IDLE:     in_stall = pend_q;
			dfr_pkg::S_HUNT_CHK: raddr = wrap({1'b0, head_q} + (AW+1)'(1));
			dfr_pkg::S_CMD:      raddr = wrap({1'b0, head_q} + (AW+1)'(2));
			dfr_pkg::S_LEN:      raddr = wrap({1'b0, head_q} + (AW+1)'(3));
			dfr_pkg::S_SUM: begin
				if (sum_done) raddr = wrap({1'b0, head_q} + (AW+1)'(len_q) + (AW+1)'(3));
				else raddr = wrap({1'b0, head_q} + (AW+1)'(idx_q) + (AW+1)'(4));
			end
			default:             raddr = head_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= dfr_pkg::S_IDLE;
		else state_q <= state_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) header_q <= dfr_pkg::HEADER_RESET;
		else if (cfg_we) header_q <= cfg_wdata;
	end

	// byte store
	always_ff @(posedge clk) begin
		if (accept) begin
			if (full) mem[head_q] <= data_byte;
			else mem[wrap({1'b0, head_q} + (AW+1)'(fill_q))] <= data_byte;
		end
		rdata_q <= mem[raddr];
	end

	// per-command counts
	always_ff @(posedge clk) begin
		if (state_q == dfr_pkg::S_CNT && move_ok) pc_mem[cmd_q] <= pc_new;
		pc_rdata_q <= pc_mem[cmd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (load_out) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			fill_q    <= '0;
			recv_q    <= '0;
			disc_q    <= '0;
			err_q     <= '0;
			valid_q   <= '0;
			pc_vld_q  <= '0;
			count_q   <= '0;
			pend_q    <= 1'b0;
		end else begin
			unique case (state_q)
				dfr_pkg::S_IDLE: if (accept) begin
					recv_q  <= recv_q + 32'd1;
					count_q <= '0;
					if (full) begin
						head_q <= wrap({1'b0, head_q} + (AW+1)'(1));
						disc_q <= disc_q + 32'd1;
					end else begin
						fill_q <= fill_q + CW'(1);
					end
				end
				dfr_pkg::S_HUNT_CHK: if (!hdr_hit) begin
					head_q <= wrap({1'b0, head_q} + (AW+1)'(1));
					fill_q <= fill_q - CW'(1);
					disc_q <= disc_q + 32'd1;
				end
				dfr_pkg::S_CHK: if (rdata_q != ~sum_q) begin
					head_q <= wrap({1'b0, head_q} + (AW+1)'(1));
					fill_q <= fill_q - CW'(1);
					disc_q <= disc_q + 32'd1;
					err_q  <= err_q + 32'd1;
				end
				dfr_pkg::S_CNT: if (move_ok) begin
					valid_q        <= valid_q + 32'd1;
					pc_vld_q[cmd_q] <= 1'b1;
					head_q  <= wrap({1'b0, head_q} + (AW+1)'(size));
					fill_q  <= fill_q - CW'(size);
					count_q <= count_q + RCW'(1);
					pend_q  <= 1'b1;
				end
				dfr_pkg::S_FIN: if (pend_q && out_free) begin
					pend_q    <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// frame fields, sum and the held descriptor
	always_ff @(posedge clk) begin
		case (state_q)
			dfr_pkg::S_CMD: cmd_q <= rdata_q;
			dfr_pkg::S_LEN: begin
				len_q <= rdata_q;
				sum_q <= cmd_q + rdata_q;
				idx_q <= '0;
			end
			dfr_pkg::S_SUM: begin
				sum_q <= sum_q + rdata_q;
				idx_q <= idx_q + 8'd1;
			end
			dfr_pkg::S_CNT: if (move_ok) begin
				if (pend_q) begin
					command         <= p_cmd_q;
					payload_length  <= p_len_q;
					frame_checksum  <= p_chk_q;
					valid_frames    <= p_valid_q;
					command_frames  <= p_cmdcnt_q;
					error_count     <= p_err_q;
					drop_count      <= p_disc_q;
					received_bytes  <= p_recv_q;
					last            <= 1'b0;
				end
				p_cmd_q    <= cmd_q;
				p_len_q    <= len_q;
				p_chk_q    <= ~sum_q;
				p_valid_q  <= valid_q + 32'd1;
				p_cmdcnt_q <= pc_new;
				p_err_q    <= err_q;
				p_disc_q   <= disc_q;
				p_recv_q   <= recv_q;
			end
			dfr_pkg::S_FIN: if (pend_q && out_free) begin
				command         <= p_cmd_q;
				payload_length  <= p_len_q;
				frame_checksum  <= p_chk_q;
				valid_frames    <= p_valid_q;
				command_frames  <= p_cmdcnt_q;
				error_count     <= p_err_q;
				drop_count      <= p_disc_q;
				received_bytes  <= p_recv_q;
				last            <= 1'b1;
			end
			default: ;
		endcase
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C) else $error("fill count beyond store depth");
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dfr_pkg::S_IDLE |-> !pend_q) else $error("descriptor held while idle");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RCW'(dfr_pkg::MAX_RESULTS)) else $error("frame count per byte too large");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == dfr_pkg::S_HUNT) else $error("transfer did not start a scan");

endmodule
